// ===== rtl/core/gcct_pkg.sv =====
// ----------------------------------------------------------------------------
// gcct_pkg
// shared constants, types and helpers for the candidate confirmation table
// ----------------------------------------------------------------------------
package gcct_pkg;

    localparam int MAX_CANDIDATES = 16;
    localparam int IDX_W          = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;

    localparam int COORD_W = 24;
    localparam int ANGLE_W = 16;
    localparam int LEN_W   = 16;
    localparam int CONF_W  = 8;

    // sine polynomial coefficients, q14
    localparam logic [15:0] SIN_A = 16'd25736;
    localparam logic [15:0] SIN_B = 16'd10512;
    localparam logic [15:0] SIN_C = 16'd1160;

    // configuration register indexes
    localparam logic [1:0] CFG_TILT      = 2'd0;
    localparam logic [1:0] CFG_GATE      = 2'd1;
    localparam logic [1:0] CFG_THRESHOLD = 2'd2;

    typedef enum logic [1:0] {
        OP_NONE     = 2'd0,
        OP_MATCH    = 2'd1,
        OP_INSERT   = 2'd2,
        OP_SCAN_END = 2'd3
    } cell_op_t;

    // search token passed along the row of cells
    typedef struct packed {
        logic              valid;
        logic              hit_found;
        logic [IDX_W-1:0]  hit_idx;
        logic [31:0]       best;
        logic [CONF_W-1:0] hit_conf;
        logic              free_found;
        logic [IDX_W-1:0]  free_idx;
    } token_t;

    // update command broadcast to every cell
    typedef struct packed {
        cell_op_t         op;
        logic [IDX_W-1:0] target;
        logic             release_slot;
    } cell_cmd_t;

    function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [25:0] v);
        logic signed [25:0] hi;
        logic signed [25:0] lo;
        hi = 26'sd8388607;
        lo = -26'sd8388608;
        if (v > hi)
            return 24'sh7FFFFF;
        else if (v < lo)
            return 24'sh800000;
        else
            return v[COORD_W-1:0];
    endfunction

endpackage

// ===== rtl/core/gated_candidate_confirmation_table_unit.sv =====
// ----------------------------------------------------------------------------
// gated_candidate_confirmation_table_unit
// nearest-neighbour gated candidate table for sonar track initiation
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  in      | input     | in_valid / in_ready    | cmd, echo_range, bearing, pose_*
//  out     | output    | out_valid / out_ready  | accepted, matched, table_full
//  cfg     | input     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// observe: projection on the shared multiplier, then the settle states while the
// cells score the point, the token walk through the MAX_CANDIDATES cells, a commit
// and a load of the output register
// end of scan: a commit, then a load of the output register; one item in flight
// reset is asynchronous and clears every slot valid bit; no clearing pass
// a stalled out channel holds the next result in the done state, blocking input
module gated_candidate_confirmation_table_unit
    import gcct_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      cmd,
    input  logic [LEN_W-1:0]          echo_range,
    input  logic [ANGLE_W-1:0]        bearing,
    input  logic signed [COORD_W-1:0] pose_x,
    input  logic signed [COORD_W-1:0] pose_y,
    input  logic [ANGLE_W-1:0]        pose_yaw,
    input  logic [ANGLE_W-1:0]        pose_pitch,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic                      accepted,
    output logic                      matched,
    output logic                      table_full,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [1:0]                cfg_index,
    input  logic [15:0]               cfg_data
);

    typedef enum logic [6:0] {
        ST_IDLE    = 7'b0000001,
        ST_PROJ    = 7'b0000010,
        ST_SETTLE1 = 7'b0000100,
        ST_SETTLE2 = 7'b0001000,
        ST_SCAN    = 7'b0010000,
        ST_COMMIT  = 7'b0100000,
        ST_DONE    = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [ANGLE_W-1:0] tilt_reg;
    logic [LEN_W-1:0]   gate_reg;
    logic [CONF_W-1:0]  thr_reg;

    // decision held between scan end and commit
    cell_op_t         op_reg, op_next;
    logic [IDX_W-1:0] target_reg, target_next;
    logic             rel_reg, rel_next;
    logic             acc_reg, acc_next;
    logic             mat_reg, mat_next;
    logic             full_reg, full_next;

    // output register
    logic out_valid_reg, out_valid_next;
    logic out_acc_reg, out_mat_reg, out_full_reg;
    logic out_load;

    logic                      in_xfer;
    logic                      proj_start;
    logic                      proj_done;
    logic signed [COORD_W-1:0] nx, ny;
    cell_cmd_t                 cell_cmd;
    token_t                    tok_seed;
    token_t                    tok [MAX_CANDIDATES+1];
    token_t                    tok_end;
    logic [CONF_W-1:0]         conf_inc;

    assign in_ready   = (state_reg == ST_IDLE);
    assign in_xfer    = in_valid && in_ready;
    assign proj_start = in_xfer && !cmd;
    assign cfg_ready  = 1'b1;

    // configuration writes, an index past the list is ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tilt_reg <= '0;
            gate_reg <= 16'd256;
            thr_reg  <= 8'd3;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_TILT:      tilt_reg <= cfg_data;
                CFG_GATE:      gate_reg <= cfg_data;
                CFG_THRESHOLD: thr_reg  <= cfg_data[CONF_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    gcct_proj u_proj (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (proj_start),
        .echo_range (echo_range),
        .elev       (pose_pitch + tilt_reg),
        .head       (pose_yaw + bearing),
        .px         (pose_x),
        .py         (pose_y),
        .done       (proj_done),
        .nx         (nx),
        .ny         (ny)
    );

    // the token enters the row seeded with the squared gate as best so far
    always_comb
    begin
        tok_seed       = '0;
        tok_seed.valid = (state_reg == ST_SETTLE2);
        tok_seed.best  = 32'(gate_reg) * 32'(gate_reg);
    end

    assign tok[0] = tok_seed;

    always_comb
    begin
        cell_cmd              = '0;
        cell_cmd.op           = (state_reg == ST_COMMIT) ? op_reg : OP_NONE;
        cell_cmd.target       = target_reg;
        cell_cmd.release_slot = rel_reg;
    end

    for (genvar i = 0; i < MAX_CANDIDATES; i++)
    begin : g_cell
        gcct_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cell_idx (IDX_W'(i)),
            .nx       (nx),
            .ny       (ny),
            .gate     (gate_reg),
            .cmd      (cell_cmd),
            .tok_in   (tok[i]),
            .tok_out  (tok[i+1])
        );
    end

    assign tok_end  = tok[MAX_CANDIDATES];
    assign conf_inc = (tok_end.hit_conf == 8'hFF) ? 8'hFF : tok_end.hit_conf + 8'd1;
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        target_next = target_reg;
        rel_next    = rel_reg;
        acc_next    = acc_reg;
        mat_next    = mat_reg;
        full_next   = full_reg;
        case (state_reg)
            ST_IDLE:
                if (in_xfer)
                begin
                    acc_next  = 1'b0;
                    mat_next  = 1'b0;
                    full_next = 1'b0;
                    rel_next  = 1'b0;
                    if (cmd)
                    begin
                        op_next    = OP_SCAN_END;
                        state_next = ST_COMMIT;
                    end
                    else
                        state_next = ST_PROJ;
                end
            ST_PROJ:
                if (proj_done)
                    state_next = ST_SETTLE1;
            ST_SETTLE1:
                state_next = ST_SETTLE2;
            ST_SETTLE2:
                state_next = ST_SCAN;
            ST_SCAN:
                if (tok_end.valid)
                begin
                    state_next = ST_COMMIT;
                    if (tok_end.hit_found)
                    begin
                        op_next     = OP_MATCH;
                        target_next = tok_end.hit_idx;
                        mat_next    = 1'b1;
                        rel_next    = (conf_inc >= thr_reg);
                        acc_next    = (conf_inc >= thr_reg);
                    end
                    else if (tok_end.free_found)
                    begin
                        op_next     = OP_INSERT;
                        target_next = tok_end.free_idx;
                    end
                    else
                    begin
                        op_next   = OP_NONE;
                        full_next = 1'b1;
                    end
                end
            ST_COMMIT:
                state_next = ST_DONE;
            ST_DONE:
                if (out_load)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            op_reg        <= OP_NONE;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            op_reg        <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        target_reg <= target_next;
        rel_reg    <= rel_next;
        acc_reg    <= acc_next;
        mat_reg    <= mat_next;
        full_reg   <= full_next;
        if (out_load)
        begin
            out_acc_reg  <= acc_reg;
            out_mat_reg  <= mat_reg;
            out_full_reg <= full_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign accepted   = out_acc_reg;
    assign matched    = out_mat_reg;
    assign table_full = out_full_reg;

endmodule

// ===== rtl/core/gcct_proj.sv =====
// ----------------------------------------------------------------------------
// gcct_proj
// projects range and bearing onto the ground plane with one shared multiplier
// ----------------------------------------------------------------------------
module gcct_proj
    import gcct_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [LEN_W-1:0]          echo_range,
    input  logic [ANGLE_W-1:0]        elev,
    input  logic [ANGLE_W-1:0]        head,
    input  logic signed [COORD_W-1:0] px,
    input  logic signed [COORD_W-1:0] py,
    output logic                      done,
    output logic signed [COORD_W-1:0] nx,
    output logic signed [COORD_W-1:0] ny
);

    localparam logic [4:0] STEP_LAST = 5'd16;

    logic                      busy_reg, busy_next;
    logic [4:0]                step_reg, step_next;
    logic                      done_reg, done_next;
    logic [LEN_W-1:0]          range_reg;
    logic [ANGLE_W-1:0]        elev_reg, head_reg;
    logic signed [COORD_W-1:0] px_reg, py_reg;
    logic [14:0]               z_reg, z2_reg, t_reg;
    logic                      neg_reg;
    logic [17:0]               plane_reg;
    logic                      plane_neg_reg;
    logic [19:0]               dx_reg;
    logic                      dx_neg_reg;
    logic signed [COORD_W-1:0] nx_reg, ny_reg;

    logic [ANGLE_W-1:0] fold_angle;
    logic signed [16:0] fold_s;
    logic [14:0]        fold_z;
    logic               fold_neg;
    logic [17:0]        mul_a;
    logic [15:0]        mul_b;
    logic [33:0]        prod;
    logic [19:0]        rnd;
    logic [14:0]        prod_q;
    logic signed [25:0] sum_x, sum_y;

    // fold the angle into a quarter turn either side of zero
    // cosine of elevation first, then cosine and sine of heading
    always_comb
    begin
        if (step_reg == 5'd5)
            fold_angle = head_reg + 16'd16384;
        else if (step_reg == 5'd10)
            fold_angle = head_reg;
        else
            fold_angle = elev_reg + 16'd16384;
        fold_s = 17'(signed'(fold_angle));
        if (fold_s > 17'sd16384)
            fold_s = 17'sd32768 - fold_s;
        else if (fold_s < -17'sd16384)
            fold_s = -17'sd32768 - fold_s;
        fold_neg = fold_s[16];
        fold_z   = fold_neg ? 15'(-fold_s) : 15'(fold_s);
    end

    always_comb
    begin
        case (step_reg)
            5'd1, 5'd6, 5'd11:
            begin
                mul_a = 18'(z_reg);
                mul_b = 16'(z_reg);
            end
            5'd2, 5'd7, 5'd12:
            begin
                mul_a = 18'(SIN_C);
                mul_b = 16'(z2_reg);
            end
            5'd3, 5'd8, 5'd13:
            begin
                mul_a = 18'(z2_reg);
                mul_b = 16'(t_reg);
            end
            5'd4, 5'd9, 5'd14:
            begin
                mul_a = 18'(z_reg);
                mul_b = 16'(t_reg);
            end
            5'd5:
            begin
                mul_a = 18'(range_reg);
                mul_b = 16'(t_reg);
            end
            5'd10, 5'd15:
            begin
                mul_a = plane_reg;
                mul_b = 16'(t_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod   = 34'(mul_a) * 34'(mul_b);
        rnd    = 20'((prod + 34'd8192) >> 14);
        prod_q = 15'(prod >> 14);
    end

    always_comb
    begin
        sum_x = 26'(px_reg) + (dx_neg_reg ? -26'(dx_reg) : 26'(dx_reg));
        sum_y = 26'(py_reg) + ((plane_neg_reg ^ neg_reg) ? -26'(rnd) : 26'(rnd));
    end

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
        end
        else if (busy_reg)
        begin
            if (step_reg == STEP_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
                step_next = step_reg + 5'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            range_reg <= echo_range;
            elev_reg  <= elev;
            head_reg  <= head;
            px_reg    <= px;
            py_reg    <= py;
        end
        else if (busy_reg)
        begin
            case (step_reg)
                5'd0, 5'd5, 5'd10:
                begin
                    z_reg   <= fold_z;
                    neg_reg <= fold_neg;
                end
                default:
                begin
                end
            endcase
            case (step_reg)
                5'd1, 5'd6, 5'd11: z2_reg <= prod_q;
                5'd2, 5'd7, 5'd12: t_reg  <= 15'(SIN_B) - prod_q;
                5'd3, 5'd8, 5'd13: t_reg  <= 15'(SIN_A) - prod_q;
                5'd4, 5'd9, 5'd14: t_reg  <= prod_q;
                default:
                begin
                end
            endcase
            if (step_reg == 5'd5)
            begin
                plane_reg     <= rnd[17:0];
                plane_neg_reg <= neg_reg;
            end
            if (step_reg == 5'd10)
            begin
                dx_reg     <= rnd;
                dx_neg_reg <= plane_neg_reg ^ neg_reg;
            end
            if (step_reg == 5'd15)
            begin
                nx_reg <= sat_coord(sum_x);
                ny_reg <= sat_coord(sum_y);
            end
        end
    end

    assign done = done_reg;
    assign nx   = nx_reg;
    assign ny   = ny_reg;

endmodule

// ===== rtl/core/gcct_cell.sv =====
// ----------------------------------------------------------------------------
// gcct_cell
// one candidate slot: holds its state, scores the point, forwards the token
// ----------------------------------------------------------------------------
module gcct_cell
    import gcct_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [IDX_W-1:0]          cell_idx,
    input  logic signed [COORD_W-1:0] nx,
    input  logic signed [COORD_W-1:0] ny,
    input  logic [LEN_W-1:0]          gate,
    input  cell_cmd_t                 cmd,
    input  token_t                    tok_in,
    output token_t                    tok_out
);

    logic                      valid_reg;
    logic                      seen_reg;
    logic [CONF_W-1:0]         conf_reg;
    logic signed [COORD_W-1:0] x_reg, y_reg;
    logic [31:0]               sqx_reg, sqy_reg;
    logic                      near_reg;
    logic [32:0]               d2_reg;
    logic                      elig_reg;
    token_t                    tok_reg, tok_next;

    logic signed [24:0] dx, dy;
    logic [24:0]        ax, ay;
    logic               near;
    logic               hit_me;

    always_comb
    begin
        dx   = 25'(x_reg) - 25'(nx);
        dy   = 25'(y_reg) - 25'(ny);
        ax   = dx[24] ? 25'(-dx) : 25'(dx);
        ay   = dy[24] ? 25'(-dy) : 25'(dy);
        // outside the gate on one axis already rules the slot out
        near = (ax < 25'(gate)) && (ay < 25'(gate));
    end

    always_ff @(posedge clk)
    begin
        sqx_reg  <= 32'(ax[15:0]) * 32'(ax[15:0]);
        sqy_reg  <= 32'(ay[15:0]) * 32'(ay[15:0]);
        near_reg <= near && valid_reg && !seen_reg;
        d2_reg   <= 33'(sqx_reg) + 33'(sqy_reg);
        elig_reg <= near_reg;
    end

    always_comb
    begin
        tok_next = tok_in;
        hit_me   = tok_in.valid && elig_reg && (d2_reg < 33'(tok_in.best));
        if (hit_me)
        begin
            tok_next.hit_found = 1'b1;
            tok_next.hit_idx   = cell_idx;
            tok_next.best      = d2_reg[31:0];
            tok_next.hit_conf  = conf_reg;
        end
        if (tok_in.valid && !valid_reg && !tok_in.free_found)
        begin
            tok_next.free_found = 1'b1;
            tok_next.free_idx   = cell_idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tok_reg <= '0;
        else
            tok_reg <= tok_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
        begin
            case (cmd.op)
                OP_MATCH:
                    if (cmd.target == cell_idx && cmd.release_slot)
                        valid_reg <= 1'b0;
                OP_INSERT:
                    if (cmd.target == cell_idx)
                        valid_reg <= 1'b1;
                OP_SCAN_END:
                    if (valid_reg && !seen_reg && conf_reg <= 8'd1)
                        valid_reg <= 1'b0;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_MATCH:
                if (cmd.target == cell_idx)
                begin
                    seen_reg <= 1'b1;
                    if (conf_reg != 8'hFF)
                        conf_reg <= conf_reg + 8'd1;
                    x_reg <= nx;
                    y_reg <= ny;
                end
            OP_INSERT:
                if (cmd.target == cell_idx)
                begin
                    seen_reg <= 1'b1;
                    conf_reg <= 8'd1;
                    x_reg    <= nx;
                    y_reg    <= ny;
                end
            OP_SCAN_END:
                if (valid_reg)
                begin
                    if (seen_reg)
                        seen_reg <= 1'b0;
                    else if (conf_reg > 8'd1)
                        conf_reg <= conf_reg - 8'd1;
                end
            default:
            begin
            end
        endcase
    end

    assign tok_out = tok_reg;

endmodule

// ===== rtl/core/gcct_checker.sv =====
// ----------------------------------------------------------------------------
// gcct_checker
// port-level checks on the candidate confirmation table
// ----------------------------------------------------------------------------
module gcct_checker
    import gcct_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic accepted,
    input logic matched,
    input logic table_full
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable({accepted, matched, table_full}))
        else $error("result changed while stalled");

    // acceptance only comes with a match
    a_acc_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && accepted |-> matched)
        else $error("accepted without match");

    // a match and a full table exclude each other
    a_full_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && table_full |-> !matched && !accepted)
        else $error("full flag with match");

    // one item at a time
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second transfer taken while busy");

endmodule

bind gated_candidate_confirmation_table_unit gcct_checker u_gcct_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .accepted   (accepted),
    .matched    (matched),
    .table_full (table_full)
);
